// ----- src/lcd3w_pkg.sv -----
// Package for the three-wire LCD master: frame codes, channel structs and helpers.
package lcd3w_pkg;

   localparam int PHASE_TICKS_W = 10;
   localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 10'd16;

   localparam int FRAME_W = 13;
   localparam int POS_W   = 4;

   localparam logic [2:0] ID_COMMAND = 3'b100;
   localparam logic [2:0] ID_WRITE   = 3'b101;
   localparam logic [2:0] ID_READ    = 3'b110;

   localparam logic [POS_W-1:0] FIRST_READ_BIT = 4'd9;
   localparam logic [POS_W-1:0] LEN_COMMAND    = 4'd12;
   localparam logic [POS_W-1:0] LEN_LONG       = 4'd13;
   localparam logic [POS_W-1:0] LAST_POS       = 4'd12;

   typedef enum logic [1:0] {
      CMD_COMMAND = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic       start_req;
      logic [1:0] cmd;
      logic [5:0] address;
      logic [3:0] nibble;
      logic [7:0] command_code;
      logic       pin_data_in;
   } tick_type;

   typedef struct packed {
      logic       chip_select_n;
      logic       write_strobe_n;
      logic       read_strobe_n;
      logic       pin_data_out;
      logic       pin_data_drive;
      logic       busy_res;
      logic       read_valid;
      logic [3:0] read_nibble;
   } result_type;

   function automatic logic [3:0] rev4(input logic [3:0] v);
      rev4 = {v[0], v[1], v[2], v[3]};
   endfunction

   function automatic logic [FRAME_W-1:0] build_frame(input logic [1:0] cmd,
                                                      input logic [5:0] address,
                                                      input logic [3:0] nibble,
                                                      input logic [7:0] code);
      case (cmd)
         CMD_COMMAND: build_frame = {ID_COMMAND, code, 2'b00};
         CMD_WRITE:   build_frame = {ID_WRITE, address, rev4(nibble)};
         CMD_READ:    build_frame = {ID_READ, address, 4'b0000};
         default:     build_frame = '0;
      endcase
   endfunction

endpackage

// ----- src/lcd3w_req_if.sv -----
// Tick input channel: valid/ready handshake and tick payload.
interface lcd3w_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [1:0] cmd;
   logic [5:0] address;
   logic [3:0] nibble;
   logic [7:0] command_code;
   logic       pin_data_in;

   modport source (output valid, start_req, cmd, address, nibble, command_code,
                   pin_data_in, input ready);
   modport sink   (input valid, start_req, cmd, address, nibble, command_code,
                   pin_data_in, output ready);
endinterface

// ----- src/lcd3w_rsp_if.sv -----
// Pin/status result channel: valid/ready handshake and pin levels.
interface lcd3w_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_select_n;
   logic       write_strobe_n;
   logic       read_strobe_n;
   logic       pin_data_out;
   logic       pin_data_drive;
   logic       busy_res;
   logic       read_valid;
   logic [3:0] read_nibble;

   modport source (output valid, chip_select_n, write_strobe_n, read_strobe_n,
                   pin_data_out, pin_data_drive, busy_res, read_valid, read_nibble,
                   input ready);
   modport sink   (input valid, chip_select_n, write_strobe_n, read_strobe_n,
                   pin_data_out, pin_data_drive, busy_res, read_valid, read_nibble,
                   output ready);
endinterface

// ----- src/lcd_driver_three_wire_master_core.sv -----
// Top level of the three-wire segment-LCD serial master.
//
//   channel   direction  handshake          contents
//   req_chan  in         valid/ready        one timing tick: start, frame request, pin sample
//   rsp_chan  out        valid/ready        pin levels and status after that tick
//   csr_*     in         write enable only  phase_ticks (ticks per bit phase)
//
// Each accepted tick updates the sequencer and loads one result into the output
// register in the same cycle, so one tick per clock is sustained while rsp_chan accepts results.
// req_chan.ready is high while the output register is empty or being drained.
// A stalled result holds in the output register; ticks wait behind it.
// Synchronous reset returns to idle, chip select high, phase_ticks 16.
module lcd_driver_three_wire_master_core (
   input  logic                                clock,
   input  logic                                reset,
   lcd3w_req_if.sink                           req_chan,
   lcd3w_rsp_if.source                         rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [lcd3w_pkg::PHASE_TICKS_W-1:0] csr_wr_data
);
   import lcd3w_pkg::*;

   tick_type   tick;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       tick_en;

   assign tick.start_req    = req_chan.start_req;
   assign tick.cmd          = req_chan.cmd;
   assign tick.address      = req_chan.address;
   assign tick.nibble       = req_chan.nibble;
   assign tick.command_code = req_chan.command_code;
   assign tick.pin_data_in  = req_chan.pin_data_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign tick_en        = req_chan.valid && req_chan.ready;

   lcd3w_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (tick_en),
      .tick        (tick),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result)
   );

   always_comb begin
      if (tick_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chip_select_n  = rsp_data_ff.chip_select_n;
   assign rsp_chan.write_strobe_n = rsp_data_ff.write_strobe_n;
   assign rsp_chan.read_strobe_n  = rsp_data_ff.read_strobe_n;
   assign rsp_chan.pin_data_out   = rsp_data_ff.pin_data_out;
   assign rsp_chan.pin_data_drive = rsp_data_ff.pin_data_drive;
   assign rsp_chan.busy_res       = rsp_data_ff.busy_res;
   assign rsp_chan.read_valid     = rsp_data_ff.read_valid;
   assign rsp_chan.read_nibble    = rsp_data_ff.read_nibble;

endmodule

// ----- src/lcd3w_seq.sv -----
// Frame sequencer: bit/phase counters, shift frame, read capture and pin levels.
module lcd3w_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick_en,
   input  lcd3w_pkg::tick_type                 tick,
   input  logic                                csr_wr_en,
   input  logic [lcd3w_pkg::PHASE_TICKS_W-1:0] csr_wr_data,
   output lcd3w_pkg::result_type               result
);
   import lcd3w_pkg::*;

   typedef enum logic [1:0] {
      PH_SETUP = 2'd0,
      PH_DATA  = 2'd1,
      PH_HIGH  = 2'd2
   } phase_type;

   logic [PHASE_TICKS_W-1:0] phase_ticks_ff;
   logic                     active_ff, active_in;
   cmd_type                  kind_ff, kind_in;
   logic [FRAME_W-1:0]       bits_ff, bits_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   phase_type                phase_ff, phase_in;
   logic [PHASE_TICKS_W-1:0] cnt_ff, cnt_in;
   logic [3:0]               rshift_ff, rshift_in;
   logic                     level_ff, level_in;

   logic [PHASE_TICKS_W-1:0] eff;
   logic                     phase_done;
   logic                     cmd_ok;
   logic                     read_bits_cur, read_bits_nxt;
   logic [POS_W-1:0]         pos_inc, bit_idx, rd_pos, frame_len;
   logic                     rv;

   always_comb begin
      eff        = (phase_ticks_ff == '0) ? PHASE_TICKS_W'(1) : phase_ticks_ff;
      phase_done = ({1'b0, cnt_ff} + (PHASE_TICKS_W+1)'(1)) >= {1'b0, eff};
      cmd_ok     = (tick.cmd == CMD_COMMAND) || (tick.cmd == CMD_WRITE) ||
                   (tick.cmd == CMD_READ);
      read_bits_cur = (kind_ff == CMD_READ) && (pos_ff >= FIRST_READ_BIT);
      pos_inc    = pos_ff + 4'd1;
      bit_idx    = LAST_POS - pos_ff;
      rd_pos     = pos_ff - FIRST_READ_BIT;
      frame_len  = (kind_ff == CMD_COMMAND) ? LEN_COMMAND : LEN_LONG;

      active_in = active_ff;
      kind_in   = kind_ff;
      bits_in   = bits_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      rshift_in = rshift_ff;
      level_in  = level_ff;
      rv        = 1'b0;

      if (!active_ff) begin
         if (tick.start_req && cmd_ok) begin
            kind_in   = cmd_type'(tick.cmd);
            bits_in   = build_frame(tick.cmd, tick.address, tick.nibble,
                                    tick.command_code);
            pos_in    = '0;
            phase_in  = PH_SETUP;
            cnt_in    = '0;
            active_in = 1'b1;
            if (tick.cmd == CMD_READ) begin
               rshift_in = '0;
            end
         end
      end else if (phase_done) begin
         cnt_in = '0;
         case (phase_ff)
            PH_SETUP: begin
               phase_in = PH_DATA;
               if (read_bits_cur) begin
                  rshift_in = rshift_ff | (4'(tick.pin_data_in) << rd_pos[1:0]);
               end else begin
                  level_in = bits_ff[bit_idx];
               end
            end
            PH_DATA: begin
               phase_in = PH_HIGH;
            end
            default: begin
               phase_in = PH_SETUP;
               pos_in   = pos_inc;
               if (pos_inc >= frame_len) begin
                  active_in = 1'b0;
                  pos_in    = '0;
                  rv        = (kind_ff == CMD_READ);
               end else if ((kind_ff == CMD_READ) && (pos_inc == FIRST_READ_BIT)) begin
                  level_in = 1'b1;
               end
            end
         endcase
      end else begin
         cnt_in = cnt_ff + PHASE_TICKS_W'(1);
      end

      read_bits_nxt = (kind_in == CMD_READ) && (pos_in >= FIRST_READ_BIT);

      result.chip_select_n  = !active_in;
      result.write_strobe_n = !(active_in && !read_bits_nxt && (phase_in != PH_HIGH));
      result.read_strobe_n  = !(active_in && read_bits_nxt && (phase_in != PH_HIGH));
      result.pin_data_out   = level_in;
      result.pin_data_drive = !(active_in && read_bits_nxt);
      result.busy_res       = active_in;
      result.read_valid     = rv;
      result.read_nibble    = rshift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         active_ff      <= 1'b0;
         kind_ff        <= CMD_COMMAND;
         bits_ff        <= '0;
         pos_ff         <= '0;
         phase_ff       <= PH_SETUP;
         cnt_ff         <= '0;
         rshift_ff      <= '0;
         level_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         if (tick_en) begin
            active_ff <= active_in;
            kind_ff   <= kind_in;
            bits_ff   <= bits_in;
            pos_ff    <= pos_in;
            phase_ff  <= phase_in;
            cnt_ff    <= cnt_in;
            rshift_ff <= rshift_in;
            level_ff  <= level_in;
         end
      end
   end

endmodule
